[design/assert_macros.svh]
// Assertion macros shared by the first-fit allocator RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset
`define AST_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Check that a condition never occurs outside reset
`define AST_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define AST_PROP(lbl, clk, rstn, prop)
`define AST_NEVER(lbl, clk, rstn, cond)

`endif

`endif

[design/ffba_pkg.sv]
// Package for the first-fit block allocator: widths, defaults, control types.
// Used by the interfaces, the controller, the datapath and the top level.
package ffba_pkg;

  // Default geometry of the managed page and its block table
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int MAX_BLOCKS_DEF = 512;

  // Allocation granule in bytes
  localparam int GRANULE     = 8;
  localparam int GRANULE_LSB = $clog2(GRANULE);

  // Fixed channel field widths
  localparam int FUNC_W = 1;
  localparam int REQ_W  = 13;
  localparam int OFF_W  = 12;

  // Request kinds
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SPLIT,
    ST_FINISH
  } fsm_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // latch a new request, restart the scan
    logic issue;     // read the next table entry
    logic wr_mark;   // write the scanned entry back marked free
    logic wr_take;   // write the scanned entry back marked taken
    logic wr_new;    // append the split remainder as a new entry
    logic wr_split;  // shrink the scanned entry to the request, taken
    logic set_res;   // record a successful allocation
    logic set_hit;   // record a free that matched
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_free;   // latched request is a free
    logic bad_size;  // latched allocate size is zero or not granular
    logic rvld;      // read data of a scanned entry is present
    logic fit;       // scanned entry is free and large enough
    logic exact;     // scanned entry is exactly the request size
    logic match;     // scanned entry starts at the free offset
    logic more;      // entries left to read
    logic full;      // table has no spare entry
    logic out_busy;  // output register holds a result not taken this cycle
  } sts_t;

endpackage

[design/ffba_if.sv]
// Handshake interfaces for the request and result channels of the allocator.
// Depends on ffba_pkg for the field widths.
interface ffba_req_if
  import ffba_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [REQ_W-1:0]  req_size;
  logic [OFF_W-1:0]  free_offset;

  modport source (output valid, output func, output req_size, output free_offset,
                  input ready);
  modport sink   (input valid, input func, input req_size, input free_offset,
                  output ready);
endinterface

interface ffba_rsp_if
  import ffba_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [OFF_W-1:0] block_offset;
  logic             ok;

  modport source (output valid, output block_offset, output ok, input ready);
  modport sink   (input valid, input block_offset, input ok, output ready);
endinterface

[design/ffba_ctrl.sv]
// Controller state machine of the first-fit allocator: sequences scan, split and result.
// Depends on ffba_pkg and assert_macros.svh; drives the datapath by command struct.
`include "assert_macros.svh"

module ffba_ctrl
  import ffba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  fsm_state_t state_r, state_nxt;
  logic       fit_now;
  logic [3:0] wr_cmds;

  // Alloc hit on the entry presented this cycle
  assign fit_now = !sts.is_free && sts.rvld && sts.fit;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.is_free) begin
          if (!sts.rvld && !sts.more) state_nxt = ST_FINISH;
        end else if (sts.bad_size) begin
          state_nxt = ST_FINISH;
        end else if (fit_now) begin
          if (sts.exact || sts.full) state_nxt = ST_FINISH;
          else                       state_nxt = ST_SPLIT;
        end else if (!sts.rvld && !sts.more) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SPLIT: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        if (sts.is_free) begin
          cmd.issue   = sts.more;
          cmd.wr_mark = sts.rvld && sts.match;
          cmd.set_hit = sts.rvld && sts.match;
        end else if (!sts.bad_size) begin
          cmd.issue = sts.more && !fit_now;
          if (fit_now) begin
            cmd.wr_take = sts.exact;
            cmd.set_res = sts.exact;
            cmd.wr_new  = !sts.exact && !sts.full;
          end
        end
      end
      ST_SPLIT: begin
        cmd.wr_split = 1'b1;
        cmd.set_res  = 1'b1;
      end
      ST_FINISH: begin
        cmd.out_load = !sts.out_busy;
      end
      default: ;
    endcase
  end

  assign wr_cmds = {cmd.wr_mark, cmd.wr_take, cmd.wr_new, cmd.wr_split};

  `AST_PROP(one_write_cmd, clk, rst_n, $onehot0(wr_cmds))
  `AST_NEVER(split_when_full, clk, rst_n, cmd.wr_new && sts.full)
  `AST_PROP(split_then_shrink, clk, rst_n, cmd.wr_new |=> cmd.wr_split)

endmodule

[design/ffba_dp.sv]
// Datapath of the first-fit allocator: block table memory, scan pointer, result registers.
// Depends on ffba_pkg and assert_macros.svh; commanded by ffba_ctrl.
`include "assert_macros.svh"

module ffba_dp
  import ffba_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [REQ_W-1:0]  in_req_size,
  input  logic [OFF_W-1:0]  in_free_offset,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OFF_W-1:0]  out_block_offset,
  output logic              out_ok
);

  localparam int SZW  = $clog2(PAGE_BYTES + 1);
  localparam int STW  = $clog2(PAGE_BYTES);
  localparam int IW   = $clog2(MAX_BLOCKS);
  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int CMPW = (SZW > REQ_W) ? SZW : REQ_W;
  localparam int OCW  = (STW > OFF_W) ? STW : OFF_W;
  localparam int SUMW = CMPW + 1;

  typedef struct packed {
    logic           free;
    logic [SZW-1:0] size;
    logic [STW-1:0] start;
  } entry_t;

  localparam entry_t ENTRY0_RST = '{free: 1'b1, size: SZW'(PAGE_BYTES), start: '0};

  // Block table
  entry_t mem [MAX_BLOCKS];

  // Latched request
  logic [FUNC_W-1:0] func_r;
  logic [REQ_W-1:0]  req_r;
  logic [OFF_W-1:0]  offs_r;

  // Scan state
  logic [CW-1:0] used_r;
  logic [CW-1:0] rd_idx_r;
  logic [IW-1:0] rd_at_r;
  logic          rvld_r;
  logic          rd_pris_r;
  logic          pristine_r;
  entry_t        raw_r;
  entry_t        cur;

  // Write port
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic [IW-1:0] rd_addr;

  // Result and output registers
  logic [OFF_W-1:0] res_off_r;
  logic             res_ok_r;
  logic             out_valid_r;
  logic [OFF_W-1:0] out_off_r;
  logic             out_ok_r;

  logic [CMPW-1:0] cur_size_w;
  logic [CMPW-1:0] req_w;
  logic [SUMW-1:0] new_start_w;

  assign rd_addr = rd_idx_r[IW-1:0];

  // Entry 0 reads as its reset contents until first written
  assign cur = rd_pris_r ? ENTRY0_RST : raw_r;

  assign cur_size_w  = CMPW'(cur.size);
  assign req_w       = CMPW'(req_r);
  assign new_start_w = SUMW'(cur.start) + SUMW'(req_r);

  // Status towards the controller
  always_comb begin
    sts.is_free  = (func_r == FUNC_FREE);
    sts.bad_size = (req_r == '0) || (req_r[GRANULE_LSB-1:0] != '0);
    sts.rvld     = rvld_r;
    sts.fit      = cur.free && (cur_size_w >= req_w);
    sts.exact    = (cur_size_w == req_w);
    sts.match    = (OCW'(cur.start) == OCW'(offs_r));
    sts.more     = (rd_idx_r < used_r);
    sts.full     = (used_r == CW'(MAX_BLOCKS));
    sts.out_busy = out_valid_r && !out_ready;
  end

  // Select the table write for this cycle
  always_comb begin
    wr_en   = cmd.wr_mark || cmd.wr_take || cmd.wr_new || cmd.wr_split;
    wr_addr = rd_at_r;
    wr_data = cur;
    if (cmd.wr_mark) begin
      wr_data.free = 1'b1;
    end else if (cmd.wr_take) begin
      wr_data.free = 1'b0;
    end else if (cmd.wr_new) begin
      wr_addr       = used_r[IW-1:0];
      wr_data.free  = 1'b1;
      wr_data.size  = SZW'(cur_size_w - req_w);
      wr_data.start = STW'(new_start_w);
    end else if (cmd.wr_split) begin
      wr_data.free = 1'b0;
      wr_data.size = SZW'(req_r);
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.issue) raw_r <= mem[rd_addr];
  end

  // Latch the request on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      req_r  <= in_req_size;
      offs_r <= in_free_offset;
    end
  end

  // Track where the read data came from
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_at_r   <= rd_addr;
      rd_pris_r <= pristine_r && (rd_addr == '0);
    end
  end

  // Advance the scan pointer and the read-data flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      rvld_r   <= 1'b0;
    end else begin
      rvld_r <= cmd.issue;
      if (cmd.load)       rd_idx_r <= '0;
      else if (cmd.issue) rd_idx_r <= rd_idx_r + CW'(1);
    end
  end

  // Count table entries in use; drop the entry 0 override once it is written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= CW'(1);
      pristine_r <= 1'b1;
    end else begin
      if (cmd.wr_new) used_r <= used_r + CW'(1);
      if (wr_en && (wr_addr == '0)) pristine_r <= 1'b0;
    end
  end

  // Collect the result of the current request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_ok_r <= 1'b0;
    end else if (cmd.load) begin
      res_ok_r <= 1'b0;
    end else if (cmd.set_res || cmd.set_hit) begin
      res_ok_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load)         res_off_r <= '0;
    else if (cmd.set_res) res_off_r <= OFF_W'(cur.start);
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_off_r <= res_off_r;
      out_ok_r  <= res_ok_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_block_offset = out_off_r;
  assign out_ok           = out_ok_r;

  `AST_NEVER(used_in_range, clk, rst_n, (used_r == '0) || (used_r > CW'(MAX_BLOCKS)))
  `AST_NEVER(rw_same_entry, clk, rst_n, wr_en && cmd.issue && (wr_addr == rd_addr))
  `AST_PROP(used_steps_by_one, clk, rst_n,
    ($past(rst_n) && (used_r != $past(used_r))) |-> (used_r == $past(used_r) + CW'(1)))

endmodule

[design/first_fit_block_allocator_top.sv]
// Top level of the first-fit block allocator: joins controller and datapath.
// Depends on ffba_pkg, the channel interfaces, ffba_ctrl and ffba_dp.
//
// in_req is a valid/ready channel carrying func (0 allocate, 1 free),
// req_size and free_offset. out_rsp returns exactly one result per request:
// block_offset (start of the allocated block, else zero) and ok.
// One request is worked on at a time, reading the table one entry per cycle
// through a single registered read port. used_r counts the table entries in use
// (1 after reset, at most MAX_BLOCKS); a free or an allocate with no fit reads
// them all before its result is loaded, an allocate stops at the first entry
// that fits and passes through ST_SPLIT when the block is split, and a bad size skips the scan.
// in_req.ready rises together with out_rsp.valid, so the next request can
// transfer while the result of the last one is shown on out_rsp.
// rst_n is synchronous, active low; after reset the table holds one free
// block covering the whole page, with no clearing pass.
// While out_rsp.ready is low the result waits in the output register; the
// next request is still taken and held at its end until the register frees.
module first_fit_block_allocator_top
  import ffba_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ffba_req_if.sink          in_req,
  ffba_rsp_if.source        out_rsp
);

  cmd_t cmd;
  sts_t sts;

  // Sequence requests
  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the block table and results
  ffba_dp #(
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_func          (in_req.func),
    .in_req_size      (in_req.req_size),
    .in_free_offset   (in_req.free_offset),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_rsp.valid),
    .out_ready        (out_rsp.ready),
    .out_block_offset (out_rsp.block_offset),
    .out_ok           (out_rsp.ok)
  );

endmodule
